@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define CMA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CMA_ASSERT(lbl, clk, rstn, prop, msg)

`define CMA_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/cma_pkg.sv @@
package cma_pkg;

  localparam int ADD_WIDTH_DEF  = 16;
  localparam int YEAR_WIDTH_DEF = 16;

  localparam logic [8:0] MIN_PER_HOUR  = 9'd60;
  localparam logic [8:0] HOUR_PER_DAY  = 9'd24;
  localparam logic [8:0] DAY_PER_YEAR  = 9'd365;
  localparam logic [8:0] DAY_PER_WEEK  = 9'd7;
  localparam logic [3:0] MONTH_PER_YR  = 4'd12;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/calendar_minute_adder.sv @@
// channel | dir | tdata fields (low bit up)                               | tuser
// in_     | in  | day 5, month 4, year 16, hour 5, minute 6, weekday 3,   | command 1
//         |     | added_minutes 16, pad 1                                 |
// out_    | out | day 5, month 4, year 16, hour 5, minute 6, weekday 3,   | -
//         |     | pad 1                                                   |
// a load item goes from idle to the done state; an add item is accepted, then runs
// four divisions by a constant (60, 24, 365, 7) on the shared multiplier, then the
// month walk, one month per cycle, and then the done state hands off the result
// in_tready is high only while the sequencer is idle; a result waits in the output
// register, the next item is taken meanwhile and holds its result until that frees
// synchronous active-low reset gives 00:00, day 1, month 1, year 0, weekday 0
`include "assert_macros.svh"

module calendar_minute_adder
  import cma_pkg::*;
#(
  parameter int ADD_WIDTH  = ADD_WIDTH_DEF,
  parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_day, load_month, load_year, load_hour, load_minute, load_weekday,
  // added_minutes
  input  logic [55:0] in_tdata,
  // command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cur_day, cur_month, cur_year, cur_hour, cur_minute, cur_weekday
  output logic [39:0] out_tdata
);

  // only the low AW bits (ADD_WIDTH, at most 16) of the added minutes reach the block
  localparam int AW = (ADD_WIDTH < 16) ? ADD_WIDTH : 16;
  localparam int XW = AW + 1;
  localparam int PW = 2 * XW;

  // floor(2^XW / d): the estimate is the quotient or one below it
  localparam logic [XW-1:0] RCP_MIN = XW'((1 << XW) / int'(MIN_PER_HOUR));
  localparam logic [XW-1:0] RCP_HR  = XW'((1 << XW) / int'(HOUR_PER_DAY));
  localparam logic [XW-1:0] RCP_YR  = XW'((1 << XW) / int'(DAY_PER_YEAR));
  localparam logic [XW-1:0] RCP_WD  = XW'((1 << XW) / int'(DAY_PER_WEEK));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RCP,
    ST_MUL_BACK,
    ST_FIX,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_MIN,
    OP_HR,
    OP_YR,
    OP_WD
  } div_op_t;

  state_t                  state_r, state_nxt;
  div_op_t                 op_r, op_nxt;
  logic [5:0]              minute_r, minute_nxt;
  logic [4:0]              hour_r, hour_nxt;
  logic [4:0]              day_r, day_nxt;
  logic [3:0]              month_r, month_nxt;
  logic [YEAR_WIDTH-1:0]   year_r, year_nxt;
  logic [2:0]              weekday_r, weekday_nxt;
  logic [XW-1:0]           dvd_r, dvd_nxt;
  logic [XW-1:0]           q_r, q_nxt;
  logic [XW-1:0]           back_r, back_nxt;
  logic [XW-1:0]           days_r, days_nxt;
  logic [8:0]              walk_r, walk_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [39:0]             out_data_r, out_data_nxt;

  logic [8:0]              div_k;
  logic [XW-1:0]           rcp_k;
  logic [XW-1:0]           mul_a;
  logic [XW-1:0]           mul_b;
  logic [PW-1:0]           mul_p;
  logic [XW-1:0]           r_hat;
  logic                    fits;
  logic [8:0]              rem_fix;
  logic [XW-1:0]           quo_fix;
  logic [4:0]              cur_len;

  logic [4:0]              ld_day;
  logic [3:0]              ld_month;
  logic [15:0]             ld_year;
  logic [4:0]              ld_hour;
  logic [5:0]              ld_minute;
  logic [2:0]              ld_weekday;
  logic [15:0]             ld_added;

  assign ld_day     = in_tdata[4:0];
  assign ld_month   = in_tdata[8:5];
  assign ld_year    = in_tdata[24:9];
  assign ld_hour    = in_tdata[29:25];
  assign ld_minute  = in_tdata[35:30];
  assign ld_weekday = in_tdata[38:36];
  assign ld_added   = in_tdata[54:39];

  always_comb begin
    unique case (op_r)
      OP_MIN: begin
        div_k = MIN_PER_HOUR;
        rcp_k = RCP_MIN;
      end
      OP_HR: begin
        div_k = HOUR_PER_DAY;
        rcp_k = RCP_HR;
      end
      OP_YR: begin
        div_k = DAY_PER_YEAR;
        rcp_k = RCP_YR;
      end
      default: begin
        div_k = DAY_PER_WEEK;
        rcp_k = RCP_WD;
      end
    endcase
  end

  // shared multiplier: reciprocal estimate, then estimate times divisor
  assign mul_a   = (state_r == ST_MUL_RCP) ? dvd_r : q_r;
  assign mul_b   = (state_r == ST_MUL_RCP) ? rcp_k : XW'(div_k);
  assign mul_p   = PW'(mul_a) * PW'(mul_b);

  // one correction step on the estimate
  assign r_hat   = dvd_r - back_r;
  assign fits    = r_hat >= XW'(div_k);
  assign rem_fix = fits ? 9'(r_hat - XW'(div_k)) : 9'(r_hat);
  assign quo_fix = fits ? q_r + XW'(1) : q_r;
  assign cur_len = month_len(month_r);

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    minute_nxt    = minute_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    weekday_nxt   = weekday_r;
    dvd_nxt       = dvd_r;
    q_nxt         = q_r;
    back_nxt      = back_r;
    days_nxt      = days_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_LOAD) begin
            day_nxt     = (ld_day == 5'd0) ? 5'd1 : ld_day;
            month_nxt   = (ld_month == 4'd0) ? 4'd1 :
                          (ld_month > MONTH_PER_YR) ? MONTH_PER_YR : ld_month;
            year_nxt    = YEAR_WIDTH'(ld_year);
            hour_nxt    = (ld_hour > 5'd23) ? 5'd23 : ld_hour;
            minute_nxt  = (ld_minute > 6'd59) ? 6'd59 : ld_minute;
            weekday_nxt = (ld_weekday == 3'd7) ? 3'd6 : ld_weekday;
            state_nxt   = ST_DONE;
          end else begin
            dvd_nxt   = XW'(minute_r) + XW'(ld_added[AW-1:0]);
            op_nxt    = OP_MIN;
            state_nxt = ST_MUL_RCP;
          end
        end
      end
      ST_MUL_RCP: begin
        q_nxt     = mul_p[PW-1:XW];
        state_nxt = ST_MUL_BACK;
      end
      ST_MUL_BACK: begin
        back_nxt  = mul_p[XW-1:0];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        state_nxt = ST_MUL_RCP;
        case (op_r)
          OP_MIN: begin
            minute_nxt = rem_fix[5:0];
            dvd_nxt    = XW'(hour_r) + quo_fix;
            op_nxt     = OP_HR;
          end
          OP_HR: begin
            hour_nxt = rem_fix[4:0];
            days_nxt = quo_fix;
            dvd_nxt  = quo_fix;
            op_nxt   = OP_YR;
          end
          OP_YR: begin
            year_nxt = year_r + YEAR_WIDTH'(quo_fix);
            walk_nxt = 9'(day_r) + rem_fix;
            dvd_nxt  = XW'(weekday_r) + days_r;
            op_nxt   = OP_WD;
          end
          default: begin
            weekday_nxt = rem_fix[2:0];
            state_nxt   = ST_WALK;
          end
        endcase
      end
      ST_WALK: begin
        if (walk_r > 9'(cur_len)) begin
          walk_nxt = walk_r - 9'(cur_len);
          if (month_r >= MONTH_PER_YR) begin
            month_nxt = 4'd1;
            year_nxt  = year_r + YEAR_WIDTH'(1);
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end else begin
          day_nxt   = walk_r[4:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, weekday_r, minute_r, hour_r, 16'(year_r), month_r, day_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_MIN;
      minute_r    <= '0;
      hour_r      <= '0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= '0;
      weekday_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      minute_r    <= minute_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      weekday_r   <= weekday_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    back_r     <= back_nxt;
    days_r     <= days_nxt;
    walk_r     <= walk_nxt;
    out_data_r <= out_data_nxt;
  end

  `CMA_ASSERT(a_month_range, clk, rst_n, (month_r >= 4'd1 && month_r <= MONTH_PER_YR), "month out of range")
  `CMA_ASSERT(a_time_range, clk, rst_n, (minute_r <= 6'd59 && hour_r <= 5'd23), "time out of range")
  `CMA_ASSERT(a_weekday_range, clk, rst_n, (weekday_r != 3'd7), "weekday out of range")
  `CMA_ASSERT(a_back_le_dvd, clk, rst_n, ((state_r == ST_FIX) |-> (back_r <= dvd_r)), "quotient estimate too large")
  `CMA_ASSERT(a_out_hold, clk, rst_n, ((out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata))), "result changed while waiting")
  `CMA_ASSERT_NR(a_reset_idle, clk, (!rst_n |=> state_r == ST_IDLE && !out_valid_r), "reset left block busy")

endmodule
